FILE: hdl/security_class_lookup_assert.svh
// ----------------------------------------------------------------------------
// security_class_lookup_assert.svh
// assertion macros for the security class lookup checkers
// ----------------------------------------------------------------------------
`ifndef SECURITY_CLASS_LOOKUP_ASSERT_SVH
`define SECURITY_CLASS_LOOKUP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SCL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// shared constants, types and default rom for the security class lookup
// ----------------------------------------------------------------------------
package scl_pkg;

	localparam int EXPLICIT_DEPTH = 16;
	localparam int ADDR_W = (EXPLICIT_DEPTH > 1) ? $clog2(EXPLICIT_DEPTH) : 1;
	localparam int LIM_W = $clog2(EXPLICIT_DEPTH + 1);

	localparam int COUNT_W = 5;
	localparam int INDEX_W = 4;
	localparam int OID_W = 16;
	localparam int MODEL_W = 16;
	localparam int KIND_W = 3;
	localparam int CLASS_W = 4;
	localparam int ROM_SIZE = 33;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [KIND_W-1:0] KIND_GET = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ACTION = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PROXY = 3'd3;

	localparam logic [CLASS_W-1:0] CLASS_NONE = 4'd15;
	localparam logic [CLASS_W-1:0] CLASS_GET_DEFAULT = 4'd4;
	localparam logic [CLASS_W-1:0] CLASS_OTHER_DEFAULT = 4'd1;
	localparam logic [CLASS_W-1:0] CLASS_DENIED = 4'd0;

	typedef struct packed {
		logic [OID_W-1:0] oid;
		logic [MODEL_W-1:0] model;
		logic [1:0] nib;
	} rom_row_t;

	typedef struct packed {
		logic found;
		logic [MODEL_W-1:0] model;
	} scl_match_t;

	typedef struct packed {
		logic done;
		logic found;
		logic [MODEL_W-1:0] model;
	} scl_scan_rsp_t;

	localparam rom_row_t ROM_TAB [ROM_SIZE] = '{
		'{16'h0FFF, 16'h8004, 2'd3}, '{16'h1FFF, 16'h4000, 2'd3},
		'{16'h202C, 16'h8004, 2'd0}, '{16'h202F, 16'h4180, 2'd0},
		'{16'h2FFF, 16'h4040, 2'd3}, '{16'h3FFF, 16'h4110, 2'd3},
		'{16'h4000, 16'h8184, 2'd0}, '{16'h4001, 16'h8104, 2'd0},
		'{16'h4002, 16'h8404, 2'd0}, '{16'h4003, 16'h4400, 2'd0},
		'{16'h400A, 16'h4500, 2'd0}, '{16'h400B, 16'h4500, 2'd0},
		'{16'h401C, 16'h4500, 2'd0}, '{16'h401D, 16'h4500, 2'd0},
		'{16'h401E, 16'h4500, 2'd0}, '{16'h4018, 16'h4000, 2'd0},
		'{16'h4019, 16'h4500, 2'd0}, '{16'h401A, 16'h4000, 2'd0},
		'{16'h401B, 16'h4500, 2'd0}, '{16'h4111, 16'h8104, 2'd0},
		'{16'h4FFF, 16'h4110, 2'd3}, '{16'h5000, 16'h4140, 2'd2},
		'{16'h50FF, 16'h4110, 2'd2}, '{16'h60FF, 16'h8887, 2'd2},
		'{16'h70FF, 16'h8085, 2'd2}, '{16'h80FF, 16'h4110, 2'd2},
		'{16'hF000, 16'h8110, 2'd0}, '{16'hF001, 16'h8220, 2'd0},
		'{16'hF002, 16'h8880, 2'd0}, '{16'hF100, 16'h8414, 2'd0},
		'{16'hF101, 16'h8124, 2'd0}, '{16'hF2FF, 16'h8887, 2'd2},
		'{16'hFFFF, 16'h8887, 2'd2}
	};

	// keeps the nibbles above the low n nibbles
	function automatic logic [OID_W-1:0] nib_mask(logic [1:0] n);
		return 16'hFFFF << {n, 2'b00};
	endfunction

endpackage

FILE: hdl/scl_item_if.sv
// ----------------------------------------------------------------------------
// scl_item_if
// input channel: one command word per handshake
// ----------------------------------------------------------------------------
interface scl_item_if;
	logic valid;
	logic ready;
	logic command;
	logic [scl_pkg::INDEX_W-1:0] entry_index;
	logic [scl_pkg::OID_W-1:0] entry_object;
	logic [scl_pkg::MODEL_W-1:0] entry_model;
	logic [scl_pkg::OID_W-1:0] object_id;
	logic [scl_pkg::KIND_W-1:0] access_kind;
	logic is_last;

	modport source (
		output valid, command, entry_index, entry_object, entry_model,
		output object_id, access_kind, is_last,
		input ready
	);

	modport sink (
		input valid, command, entry_index, entry_object, entry_model,
		input object_id, access_kind, is_last,
		output ready
	);
endinterface

FILE: hdl/scl_result_if.sv
// ----------------------------------------------------------------------------
// scl_result_if
// output channel: one result word per request list
// ----------------------------------------------------------------------------
interface scl_result_if;
	logic valid;
	logic ready;
	logic [scl_pkg::CLASS_W-1:0] security_class;
	logic kind_invalid;

	modport source (
		output valid, security_class, kind_invalid,
		input ready
	);

	modport sink (
		input valid, security_class, kind_invalid,
		output ready
	);
endinterface

FILE: hdl/scl_default_rom.sv
// ----------------------------------------------------------------------------
// scl_default_rom
// parallel match of one object id against the built-in default entries
// ----------------------------------------------------------------------------
module scl_default_rom (
	input logic clk,
	input logic start,
	input logic [scl_pkg::OID_W-1:0] object_id,
	output scl_pkg::scl_match_t match
);
	import scl_pkg::*;

	logic [ROM_SIZE-1:0] hit;
	logic [3:0] fnd;
	logic [MODEL_W-1:0] mdl [4];
	scl_match_t match_d;
	scl_match_t match_q;

	always_comb begin
		for (int i = 0; i < ROM_SIZE; i++) begin
			hit[i] = ((object_id ^ ROM_TAB[i].oid) & nib_mask(ROM_TAB[i].nib)) == '0;
		end
	end

	// first hit per mask size
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			fnd[n] = 1'b0;
			mdl[n] = '0;
			for (int i = ROM_SIZE - 1; i >= 0; i--) begin
				if (hit[i] && ROM_TAB[i].nib == 2'(n)) begin
					fnd[n] = 1'b1;
					mdl[n] = ROM_TAB[i].model;
				end
			end
		end
	end

	always_comb begin
		priority if (fnd[0]) begin
			match_d = '{found: 1'b1, model: mdl[0]};
		end else if (fnd[1]) begin
			match_d = '{found: (mdl[1] != '0), model: mdl[1]};
		end else if (fnd[2]) begin
			match_d = '{found: (mdl[2] != '0), model: mdl[2]};
		end else if (fnd[3]) begin
			match_d = '{found: (mdl[3] != '0), model: mdl[3]};
		end else begin
			match_d = '{found: 1'b0, model: '0};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			match_q <= match_d;
		end
	end

	assign match = match_q;
endmodule

FILE: hdl/scl_explicit_scan.sv
// ----------------------------------------------------------------------------
// scl_explicit_scan
// explicit table memory and the sequencer that scans it one slot per cycle
// ----------------------------------------------------------------------------
module scl_explicit_scan (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [scl_pkg::INDEX_W-1:0] wr_index,
	input logic [scl_pkg::OID_W-1:0] wr_object,
	input logic [scl_pkg::MODEL_W-1:0] wr_model,
	input logic start,
	input logic [scl_pkg::OID_W-1:0] object_id,
	input logic [scl_pkg::COUNT_W-1:0] count,
	output scl_pkg::scl_scan_rsp_t rsp
);
	import scl_pkg::*;

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t state_q;
	logic [OID_W+MODEL_W-1:0] mem [EXPLICIT_DEPTH];
	logic [OID_W+MODEL_W-1:0] rd_data_s1;
	logic [OID_W-1:0] oid_q;
	logic [LIM_W-1:0] lim;
	logic [LIM_W-1:0] lim_q;
	logic [LIM_W-1:0] nxt_q;
	logic valid_s1;
	logic last_s1;
	logic hit;
	logic finish;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;

	assign lim = (32'(count) > EXPLICIT_DEPTH) ? LIM_W'(EXPLICIT_DEPTH) : LIM_W'(count);
	assign hit = valid_s1 && (rd_data_s1[OID_W+MODEL_W-1:MODEL_W] == oid_q);
	assign finish = (state_q == ST_SCAN) && (!valid_s1 || hit || last_s1);

	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				rd_en = start && (lim != '0);
				rd_addr = '0;
			end
			ST_SCAN: begin
				rd_en = !finish && (nxt_q < lim_q);
				rd_addr = nxt_q[ADDR_W-1:0];
			end
			default: begin
				rd_en = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	// writes only arrive between lookups, so no read can meet a write
	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_index) < EXPLICIT_DEPTH)) begin
			mem[ADDR_W'(wr_index)] <= {wr_object, wr_model};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			oid_q <= object_id;
			lim_q <= lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nxt_q <= '0;
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						nxt_q <= LIM_W'(1);
						valid_s1 <= (lim != '0);
						last_s1 <= (lim == LIM_W'(1));
					end else begin
						valid_s1 <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q <= ST_IDLE;
						valid_s1 <= 1'b0;
					end else begin
						valid_s1 <= rd_en;
						last_s1 <= (nxt_q + LIM_W'(1)) == lim_q;
						nxt_q <= nxt_q + LIM_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = finish;
	assign rsp.found = hit;
	assign rsp.model = rd_data_s1[MODEL_W-1:0];
endmodule

FILE: hdl/security_class_lookup.sv
// ----------------------------------------------------------------------------
// security_class_lookup
// classifies the objects of a request list and returns the strictest class
// ----------------------------------------------------------------------------
// channel  dir  words
// item     in   table write (command 0) or one list object (command 1)
// result   out  security_class, kind_invalid, one per list
// cfg      in   explicit_count, write only
//
// a table write or an object with an invalid kind needs no scan; any other object
// scans the explicit slots in order, up to min(count,16), stopping at the first hit
// the object marked last then passes through ST_PUSH to load the result register
// default entries are matched in parallel during the scan
// reset leaves the table contents undefined; no clearing pass
// a held result stalls the block only when the next list ends
module security_class_lookup (
	input logic clk,
	input logic arst_n,
	scl_item_if.sink item,
	scl_result_if.source result,
	input logic cfg_we,
	input logic [scl_pkg::COUNT_W-1:0] cfg_wdata
);
	import scl_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_PUSH} state_t;

	state_t state_q;
	logic [COUNT_W-1:0] count_q;
	logic [CLASS_W-1:0] min_q;
	logic err_q;
	logic [KIND_W-1:0] kind_q;
	logic last_q;
	logic [CLASS_W-1:0] res_class_q;
	logic res_inv_q;
	logic out_valid_q;
	logic [CLASS_W-1:0] out_class_q;
	logic out_inv_q;

	logic accept;
	logic wr_en;
	logic kind_bad;
	logic start;
	logic load_out;
	scl_scan_rsp_t scan_rsp;
	scl_match_t rom_match;
	logic found_any;
	logic [MODEL_W-1:0] model_sel;
	logic [CLASS_W-1:0] cls;
	logic [CLASS_W-1:0] new_min;
	logic [CLASS_W-1:0] fin_class;

	function automatic logic [CLASS_W-1:0] pick_nibble(logic [MODEL_W-1:0] model,
			logic [KIND_W-1:0] kind);
		logic [CLASS_W-1:0] nib;
		unique case (kind)
			KIND_GET: nib = model[15:12];
			KIND_SET: nib = model[11:8];
			KIND_ACTION: nib = model[7:4];
			default: nib = model[3:0];
		endcase
		return nib;
	endfunction

	assign item.ready = (state_q == ST_IDLE);
	assign accept = item.valid && item.ready;
	assign wr_en = accept && (item.command == CMD_WRITE);
	assign kind_bad = item.access_kind > KIND_PROXY;
	assign start = accept && (item.command == CMD_LOOKUP) && !kind_bad;
	assign load_out = (state_q == ST_PUSH) && (!out_valid_q || result.ready);

	scl_explicit_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(item.entry_index),
		.wr_object(item.entry_object),
		.wr_model(item.entry_model),
		.start(start),
		.object_id(item.object_id),
		.count(count_q),
		.rsp(scan_rsp)
	);

	scl_default_rom u_rom (
		.clk(clk),
		.start(start),
		.object_id(item.object_id),
		.match(rom_match)
	);

	// explicit hit wins over the default entries
	assign found_any = scan_rsp.found || rom_match.found;
	assign model_sel = scan_rsp.found ? scan_rsp.model : rom_match.model;
	assign cls = pick_nibble(model_sel, kind_q);
	assign new_min = (found_any && (cls < min_q)) ? cls : min_q;

	always_comb begin
		if (err_q) begin
			fin_class = CLASS_DENIED;
		end else if (new_min != CLASS_NONE) begin
			fin_class = new_min;
		end else if (kind_q == KIND_GET) begin
			fin_class = CLASS_GET_DEFAULT;
		end else begin
			fin_class = CLASS_OTHER_DEFAULT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			min_q <= CLASS_NONE;
			err_q <= 1'b0;
			kind_q <= KIND_GET;
			last_q <= 1'b0;
			res_class_q <= '0;
			res_inv_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_class_q <= '0;
			out_inv_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.command == CMD_LOOKUP) begin
						kind_q <= item.access_kind;
						last_q <= item.is_last;
						if (!kind_bad) begin
							state_q <= ST_LOOK;
						end else if (item.is_last) begin
							res_class_q <= CLASS_DENIED;
							res_inv_q <= 1'b1;
							min_q <= CLASS_NONE;
							err_q <= 1'b0;
							state_q <= ST_PUSH;
						end else begin
							err_q <= 1'b1;
						end
					end
				end
				ST_LOOK: begin
					if (scan_rsp.done) begin
						if (last_q) begin
							res_class_q <= fin_class;
							res_inv_q <= err_q;
							min_q <= CLASS_NONE;
							err_q <= 1'b0;
							state_q <= ST_PUSH;
						end else begin
							min_q <= new_min;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PUSH: begin
					if (load_out) begin
						out_class_q <= res_class_q;
						out_inv_q <= res_inv_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.security_class = out_class_q;
	assign result.kind_invalid = out_inv_q;
endmodule

FILE: hdl/scl_port_checker.sv
// ----------------------------------------------------------------------------
// scl_port_checker
// port level checks of the security class lookup, bound to the top level
// ----------------------------------------------------------------------------
`include "security_class_lookup_assert.svh"

module scl_port_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic item_command,
	input logic item_is_last,
	input logic result_valid,
	input logic result_ready,
	input logic [scl_pkg::CLASS_W-1:0] security_class,
	input logic kind_invalid
);
	import scl_pkg::*;

	// stalled result word holds
	`SCL_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(security_class) && $stable(kind_invalid), "result word changed while stalled")

	// error result carries the denied class
	`SCL_ASSERT_SAME(a_error_class, result_valid && kind_invalid, security_class == CLASS_DENIED, "kind error without denied class")

	// the not-found marker never leaves the block
	`SCL_ASSERT_SAME(a_no_marker, result_valid && !kind_invalid, security_class != CLASS_NONE, "unresolved class on result")

	// end of list is followed by a busy cycle
	`SCL_ASSERT_NEXT(a_last_busy, item_valid && item_ready && item_command == CMD_LOOKUP && item_is_last, !item_ready, "ready right after end of list")
endmodule

bind security_class_lookup scl_port_checker u_port_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.item_command(item.command),
	.item_is_last(item.is_last),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.security_class(result.security_class),
	.kind_invalid(result.kind_invalid)
);

FILE: tb/tb_security_class_lookup.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_security_class_lookup
// self-checking bench for the security class lookup: loads the explicit
// table, walks the default table cases and the explicit table cases, then
// runs random request lists and table writes under several explicit counts
// and idle patterns; every result word is checked against a behavioral
// predictor of the lookup
module tb_security_class_lookup;
	import scl_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int TIMEOUT_NS = 5_000_000;
	localparam logic [KIND_W-1:0] KIND_MAX = 3'd7;

	typedef struct packed {
		logic [OID_W-1:0] oid;
		logic [MODEL_W-1:0] model;
		logic [1:0] nib;
	} policy_row_t;

	typedef struct packed {
		logic command;
		logic [INDEX_W-1:0] entry_index;
		logic [OID_W-1:0] entry_object;
		logic [MODEL_W-1:0] entry_model;
		logic [OID_W-1:0] object_id;
		logic [KIND_W-1:0] access_kind;
		logic is_last;
	} req_word_t;

	typedef struct packed {
		logic [CLASS_W-1:0] security_class;
		logic kind_invalid;
	} class_result_t;

	localparam policy_row_t DEFAULT_POLICY [ROM_SIZE] = '{
		'{16'h0FFF, 16'h8004, 2'd3}, '{16'h1FFF, 16'h4000, 2'd3},
		'{16'h202C, 16'h8004, 2'd0}, '{16'h202F, 16'h4180, 2'd0},
		'{16'h2FFF, 16'h4040, 2'd3}, '{16'h3FFF, 16'h4110, 2'd3},
		'{16'h4000, 16'h8184, 2'd0}, '{16'h4001, 16'h8104, 2'd0},
		'{16'h4002, 16'h8404, 2'd0}, '{16'h4003, 16'h4400, 2'd0},
		'{16'h400A, 16'h4500, 2'd0}, '{16'h400B, 16'h4500, 2'd0},
		'{16'h401C, 16'h4500, 2'd0}, '{16'h401D, 16'h4500, 2'd0},
		'{16'h401E, 16'h4500, 2'd0}, '{16'h4018, 16'h4000, 2'd0},
		'{16'h4019, 16'h4500, 2'd0}, '{16'h401A, 16'h4000, 2'd0},
		'{16'h401B, 16'h4500, 2'd0}, '{16'h4111, 16'h8104, 2'd0},
		'{16'h4FFF, 16'h4110, 2'd3}, '{16'h5000, 16'h4140, 2'd2},
		'{16'h50FF, 16'h4110, 2'd2}, '{16'h60FF, 16'h8887, 2'd2},
		'{16'h70FF, 16'h8085, 2'd2}, '{16'h80FF, 16'h4110, 2'd2},
		'{16'hF000, 16'h8110, 2'd0}, '{16'hF001, 16'h8220, 2'd0},
		'{16'hF002, 16'h8880, 2'd0}, '{16'hF100, 16'h8414, 2'd0},
		'{16'hF101, 16'h8124, 2'd0}, '{16'hF2FF, 16'h8887, 2'd2},
		'{16'hFFFF, 16'h8887, 2'd2}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	scl_item_if item_bus();
	scl_result_if result_bus();

	logic [OID_W+MODEL_W-1:0] policy_tbl [EXPLICIT_DEPTH];
	logic [COUNT_W-1:0] tbl_count;
	logic [CLASS_W-1:0] strictest;
	logic bad_kind_seen;
	class_result_t class_q [$];
	class_result_t due;
	int mismatch_count;
	int src_idle_pct;
	int sink_idle_pct;

	security_class_lookup u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial result_bus.ready = 1'b0;
	always @(posedge clk) begin
		result_bus.ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 50)
			$display("%0t ERROR %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (class_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result word class %0d invalid %0b",
					result_bus.security_class, result_bus.kind_invalid));
			end else begin
				due = class_q.pop_front();
				if (result_bus.security_class !== due.security_class)
					report_mismatch($sformatf("security_class got %0d expected %0d",
						result_bus.security_class, due.security_class));
				if (result_bus.kind_invalid !== due.kind_invalid)
					report_mismatch($sformatf("kind_invalid got %0b expected %0b",
						result_bus.kind_invalid, due.kind_invalid));
			end
		end
	end

	function automatic bit find_policy(input logic [OID_W-1:0] oid,
			output logic [MODEL_W-1:0] model);
		int lim;
		logic [1:0] best_nib;
		logic [MODEL_W-1:0] best_model;
		logic [OID_W-1:0] keep;
		lim = (tbl_count > EXPLICIT_DEPTH) ? EXPLICIT_DEPTH : int'(tbl_count);
		best_nib = 2'd0;
		best_model = '0;
		model = '0;
		for (int i = 0; i < lim; i++) begin
			if (policy_tbl[i][OID_W+MODEL_W-1:MODEL_W] == oid) begin
				model = policy_tbl[i][MODEL_W-1:0];
				return 1'b1;
			end
		end
		for (int i = 0; i < ROM_SIZE; i++) begin
			keep = 16'hFFFF << (4 * DEFAULT_POLICY[i].nib);
			if ((oid & keep) != (DEFAULT_POLICY[i].oid & keep))
				continue;
			if (DEFAULT_POLICY[i].nib == 2'd0) begin
				model = DEFAULT_POLICY[i].model;
				return 1'b1;
			end
			if (best_nib == 2'd0 || DEFAULT_POLICY[i].nib < best_nib) begin
				best_nib = DEFAULT_POLICY[i].nib;
				best_model = DEFAULT_POLICY[i].model;
			end
		end
		if (best_nib != 2'd0 && best_model != '0) begin
			model = best_model;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void classify_word(input req_word_t w);
		logic [MODEL_W-1:0] model;
		logic [CLASS_W-1:0] cls;
		class_result_t res;
		if (w.command == CMD_WRITE) begin
			policy_tbl[w.entry_index] = {w.entry_object, w.entry_model};
			return;
		end
		if (w.access_kind > KIND_PROXY) begin
			bad_kind_seen = 1'b1;
		end else if (find_policy(w.object_id, model)) begin
			cls = CLASS_W'(model >> (12 - 4 * w.access_kind));
			if (cls < strictest)
				strictest = cls;
		end
		if (!w.is_last)
			return;
		if (bad_kind_seen) begin
			res.security_class = CLASS_DENIED;
			res.kind_invalid = 1'b1;
		end else begin
			cls = strictest;
			if (cls == CLASS_NONE)
				cls = (w.access_kind == KIND_GET) ? CLASS_GET_DEFAULT : CLASS_OTHER_DEFAULT;
			res.security_class = cls;
			res.kind_invalid = 1'b0;
		end
		class_q.push_back(res);
		strictest = CLASS_NONE;
		bad_kind_seen = 1'b0;
	endfunction

	task automatic send_word(input req_word_t w);
		while ($urandom_range(99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.command <= w.command;
		item_bus.entry_index <= w.entry_index;
		item_bus.entry_object <= w.entry_object;
		item_bus.entry_model <= w.entry_model;
		item_bus.object_id <= w.object_id;
		item_bus.access_kind <= w.access_kind;
		item_bus.is_last <= w.is_last;
		do @(posedge clk); while (!item_bus.ready);
		classify_word(w);
	endtask

	// unused fields carry random junk
	task automatic send_entry(input logic [INDEX_W-1:0] slot, input logic [OID_W-1:0] obj,
			input logic [MODEL_W-1:0] model);
		req_word_t w;
		w.command = CMD_WRITE;
		w.entry_index = slot;
		w.entry_object = obj;
		w.entry_model = model;
		w.object_id = OID_W'($urandom);
		w.access_kind = KIND_W'($urandom);
		w.is_last = 1'($urandom);
		send_word(w);
	endtask

	task automatic send_lookup(input logic [OID_W-1:0] oid, input logic [KIND_W-1:0] kind,
			input logic last);
		req_word_t w;
		w.command = CMD_LOOKUP;
		w.entry_index = INDEX_W'($urandom);
		w.entry_object = OID_W'($urandom);
		w.entry_model = MODEL_W'($urandom);
		w.object_id = oid;
		w.access_kind = kind;
		w.is_last = last;
		send_word(w);
	endtask

	task automatic settle_block();
		item_bus.valid <= 1'b0;
		while (class_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] value);
		settle_block();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tbl_count = value;
	endtask

	function automatic logic [OID_W-1:0] pick_object();
		policy_row_t row;
		logic [OID_W-1:0] keep;
		row = DEFAULT_POLICY[$urandom_range(ROM_SIZE - 1)];
		keep = 16'hFFFF << (4 * row.nib);
		case ($urandom_range(5))
			0: return policy_tbl[$urandom_range(EXPLICIT_DEPTH - 1)][OID_W+MODEL_W-1:MODEL_W];
			1: return row.oid;
			2: return (row.oid & keep) | (OID_W'($urandom) & ~keep);
			3: return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
			default: return OID_W'($urandom);
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		if ($urandom_range(11) == 0)
			return KIND_W'($urandom_range(KIND_PROXY + 1, KIND_MAX));
		return KIND_W'($urandom_range(KIND_GET, KIND_PROXY));
	endfunction

	task automatic test_table_load();
		send_entry(4'd0, 16'h4000, 16'h2222);
		send_entry(4'd1, 16'h4000, 16'h1111);
		send_entry(4'd2, 16'hFFFF, 16'hFFFF);
		send_entry(4'd3, 16'h0000, 16'h0000);
		send_entry(4'd4, 16'h9000, 16'h8421);
		for (int i = 5; i < EXPLICIT_DEPTH; i++)
			send_entry(INDEX_W'(i), OID_W'($urandom), MODEL_W'($urandom));
		settle_block();
	endtask

	task automatic test_default_table();
		send_lookup(16'h4000, KIND_GET, 1'b1);
		send_lookup(16'h1234, KIND_SET, 1'b1);
		send_lookup(16'h5012, KIND_ACTION, 1'b1);
		send_lookup(16'hFF12, KIND_PROXY, 1'b1);
		send_lookup(16'h9000, KIND_GET, 1'b1);
		send_lookup(16'h9000, KIND_PROXY, 1'b1);
		send_lookup(16'h202C, KIND_GET, 1'b0);
		send_lookup(16'h0000, KIND_SET, 1'b0);
		send_lookup(16'hFFFF, KIND_ACTION, 1'b1);
		send_lookup(16'h4000, KIND_MAX, 1'b1);
		send_lookup(16'h4111, KIND_PROXY + 3'd1, 1'b0);
		send_lookup(16'h4000, KIND_GET, 1'b1);
		settle_block();
	endtask

	task automatic test_explicit_table();
		write_count(COUNT_W'(EXPLICIT_DEPTH));
		send_lookup(16'h4000, KIND_SET, 1'b1);
		send_lookup(16'hFFFF, KIND_GET, 1'b1);
		send_lookup(16'h0000, KIND_ACTION, 1'b1);
		send_lookup(16'h9000, KIND_SET, 1'b0);
		send_lookup(16'hABCD, KIND_GET, 1'b1);
		settle_block();
	endtask

	task automatic test_random_traffic(input int n_words);
		int sent;
		int len;
		sent = 0;
		while (sent < n_words) begin
			if ($urandom_range(9) == 0) begin
				send_entry(INDEX_W'($urandom), pick_object(), MODEL_W'($urandom));
				sent++;
			end else begin
				len = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					send_lookup(pick_object(), pick_kind(), k == len - 1);
				sent += len;
			end
		end
		settle_block();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_bus.valid = 1'b0;
		item_bus.command = CMD_WRITE;
		item_bus.entry_index = '0;
		item_bus.entry_object = '0;
		item_bus.entry_model = '0;
		item_bus.object_id = '0;
		item_bus.access_kind = KIND_GET;
		item_bus.is_last = 1'b0;
		for (int i = 0; i < EXPLICIT_DEPTH; i++)
			policy_tbl[i] = '0;
		tbl_count = '0;
		strictest = CLASS_NONE;
		bad_kind_seen = 1'b0;
		mismatch_count = 0;
		src_idle_pct = 22;
		sink_idle_pct = 82;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_default_table();
		test_explicit_table();

		write_count(5'd31);
		test_random_traffic(100);
		write_count(5'd7);
		test_random_traffic(100);

		src_idle_pct = 82;
		sink_idle_pct = 22;
		write_count(5'd1);
		test_random_traffic(100);
		write_count(5'd12);
		test_random_traffic(100);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		write_count(5'd0);
		test_random_traffic(100);
		write_count(COUNT_W'(EXPLICIT_DEPTH));
		test_random_traffic(100);

		settle_block();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/scl_pkg.sv
hdl/scl_item_if.sv
hdl/scl_result_if.sv
hdl/scl_default_rom.sv
hdl/scl_explicit_scan.sv
hdl/security_class_lookup.sv
hdl/scl_port_checker.sv
tb/tb_security_class_lookup.sv
